### design/bounded_unique_set_table_core_assert.svh
// Assertion macros used by the checker module of the set table.
`ifndef BOUNDED_UNIQUE_SET_TABLE_CORE_ASSERT_SVH
`define BOUNDED_UNIQUE_SET_TABLE_CORE_ASSERT_SVH

// Clocked assertion with reset disable and a fixed failure message.
`define BUST_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("set table assertion failed");

// Clocked assertion with reset disable and a caller-supplied message.
`define BUST_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

### design/bust_pkg.sv
// Package with the types and constants of the bounded unique set table.
package bust_pkg;

  // Default configuration of the table.
  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // Input beat layout: command in the low bits, then the key.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned IN_TDATA_W  = ((CMD_W + KEY_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } bust_cmd_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic      apply;
    bust_cmd_e cmd;
    logic      present;
  } bust_ctrl_t;

endpackage

### design/bust_cell.sv
// One storage cell of the set table: holds a key and passes the scan token on.
module bust_cell #(
  parameter int unsigned CAPACITY  = bust_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = bust_pkg::KEY_WIDTH_DEF,
  parameter int unsigned IDX       = 0,
  localparam int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bust_pkg::bust_ctrl_t ctrl_i,
  input  logic [CntW-1:0]      count_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [KEY_WIDTH-1:0] last_key_i,
  input  logic                 tok_vld_i,
  input  logic                 hit_i,
  input  logic [KEY_WIDTH-1:0] last_i,
  output logic                 tok_vld_o,
  output logic                 hit_o,
  output logic [KEY_WIDTH-1:0] last_o
);
  import bust_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(IDX);

  logic [KEY_WIDTH-1:0] key_q;
  logic                 tok_vld_q;
  logic                 hit_q;
  logic                 match_q;
  logic [KEY_WIDTH-1:0] last_q;
  logic                 occupied;
  logic                 is_last;
  logic                 match_d;
  logic                 wr_ins;
  logic                 wr_rem;

  // Slot state relative to the current fill count.
  assign occupied = IdxC < count_i;
  assign is_last  = (IdxC + CntW'(1)) == count_i;
  assign match_d  = occupied && (key_q == key_i);

  // Write-back decisions taken after the scan has finished.
  assign wr_ins = ctrl_i.apply && (ctrl_i.cmd == CMD_INSERT) && !ctrl_i.present &&
                  (IdxC == count_i);
  assign wr_rem = ctrl_i.apply && (ctrl_i.cmd == CMD_REMOVE) && match_q;

  // Scan token stage: one cell per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      match_q   <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      if (tok_vld_i) begin
        hit_q   <= hit_i | match_d;
        match_q <= match_d;
      end
    end
  end

  // The token picks up the last stored key on its way down the row.
  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      last_q <= is_last ? key_q : last_i;
    end
  end

  // Stored key: appended on insert, overwritten by the last key on remove.
  always_ff @(posedge clk_i) begin
    if (wr_ins) begin
      key_q <= key_i;
    end else if (wr_rem) begin
      key_q <= last_key_i;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign hit_o     = hit_q;
  assign last_o    = last_q;

endmodule

### design/bounded_unique_set_table_core.sv
// Top level of the bounded unique set table: sequencer and the row of cells.
//
//  channel  dir  beat contents (lowest bits first)
//  s_axis   in   command[1:0], key[33:2]
//  m_axis   out  was_present[0], count[CntW:1], status[CntW+1]
//
// Each accepted item is scanned and then written back: the scan token walks the
// row of cells one cell per cycle, then the write-back step writes into the
// cells and loads the output register, waiting while the output is stalled.
// Reset clears the fill count and all control state; stored keys are not
// cleared. A stalled output holds the finished result, and the next item is
// accepted only once the current item has been written back.
module bounded_unique_set_table_core #(
  parameter int unsigned CAPACITY  = bust_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = bust_pkg::KEY_WIDTH_DEF,
  localparam int unsigned CntW     = $clog2(CAPACITY + 1),
  localparam int unsigned OutW     = ((CntW + 2 + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // command[1:0], key[33:2], zero pad above
  input  logic [bust_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // was_present[0], count[CntW:1], status[CntW+1], zero pad above
  output logic [OutW-1:0]                 m_axis_tdata_o
);
  import bust_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e               state_q;
  bust_cmd_e            cmd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      count_d;
  logic                 out_vld_q;
  logic                 was_q;
  logic                 status_q;
  logic                 status_d;
  logic                 start_q;
  logic                 s_acc;
  logic                 out_free;
  logic                 apply;
  logic                 full;
  bust_ctrl_t           ctrl;

  logic                 tok_vld [CAPACITY+1];
  logic                 hit     [CAPACITY+1];
  logic [KEY_WIDTH-1:0] last    [CAPACITY+1];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign apply           = (state_q == ST_APPLY) && out_free;
  assign full            = (count_q == CntW'(CAPACITY));

  // Control broadcast to the cells.
  assign ctrl.apply      = apply;
  assign ctrl.cmd        = cmd_q;
  assign ctrl.present    = hit[CAPACITY];

  // Head of the scan chain: the token starts once the key register holds the new key.
  assign tok_vld[0] = start_q;
  assign hit[0]     = 1'b0;
  assign last[0]    = '0;

  // Row of cells, one stored key each.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bust_cell #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(KEY_WIDTH),
      .IDX      (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .key_i     (key_q),
      .last_key_i(last[CAPACITY]),
      .tok_vld_i (tok_vld[g]),
      .hit_i     (hit[g]),
      .last_i    (last[g]),
      .tok_vld_o (tok_vld[g+1]),
      .hit_o     (hit[g+1]),
      .last_o    (last[g+1])
    );
  end

  // New fill count and status once the scan result is known.
  always_comb begin
    count_d  = count_q;
    status_d = 1'b0;
    case (cmd_q)
      CMD_INSERT: begin
        if (!hit[CAPACITY]) begin
          if (full) begin
            status_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (hit[CAPACITY]) begin
          count_d = count_q - CntW'(1);
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= CMD_LOOKUP;
      key_q     <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      was_q     <= 1'b0;
      status_q  <= 1'b0;
      start_q   <= 1'b0;
    end else begin
      start_q <= s_acc;
      if (apply) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            cmd_q   <= bust_cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
            key_q   <= KEY_WIDTH'(s_axis_tdata_i[CMD_W+KEY_FIELD_W-1:CMD_W]);
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok_vld[CAPACITY]) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (out_free) begin
            count_q  <= count_d;
            was_q    <= hit[CAPACITY];
            status_q <= status_d;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutW'({status_q, count_q, was_q});

endmodule

### design/bust_checker.sv
// Port-level checker for the set table, bound to the top level.
`include "bounded_unique_set_table_core_assert.svh"

module bust_checker #(
  parameter int unsigned CAPACITY = bust_pkg::CAPACITY_DEF,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1),
  localparam int unsigned OutW    = ((CntW + 2 + 7) / 8) * 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [bust_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [OutW-1:0]                 m_axis_tdata_o
);
  import bust_pkg::*;

  logic [CntW-1:0] out_count;
  logic            out_status;
  logic            out_was;

  assign out_was    = m_axis_tdata_o[0];
  assign out_count  = m_axis_tdata_o[CntW:1];
  assign out_status = m_axis_tdata_o[CntW+1];

  // A stalled result beat holds.
  `BUST_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // After an accepted item the input side closes for the scan.
  `BUST_ASSERT_MSG(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input accepted during a scan")

  // The fill count never exceeds the capacity.
  `BUST_ASSERT_MSG(a_count_bound, clk_i, rst_ni, m_axis_tvalid_o |-> out_count <= CntW'(CAPACITY), "count above capacity")

  // A full status only comes with a full table and an absent key.
  `BUST_ASSERT_MSG(a_full_status, clk_i, rst_ni, m_axis_tvalid_o && out_status |-> out_count == CntW'(CAPACITY) && !out_was, "full status without a full table")

  // A new result appears only after the input side has been closed.
  `BUST_ASSERT(a_result_after_scan, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))

endmodule

bind bounded_unique_set_table_core bust_checker #(
  .CAPACITY(CAPACITY)
) u_bust_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
